>>> rtl/rpn_pkg.sv
// Shared types and constants of the RPN stack calculator.
package rpn_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_NUM   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_MOD   = 3'd5,
    OP_PRINT = 3'd6,
    OP_UNK   = 3'd7
  } rpn_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_B,
    S_WAIT_B,
    S_CHK_B,
    S_POP_A,
    S_WAIT_A,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DIV_FIN,
    S_PUSH,
    S_DONE
  } rpn_state_t;

  typedef struct packed {
    logic    accept;
    logic    tok_unk;
    logic    pop_b;
    logic    pop_a;
    logic    set_print;
    logic    set_divz;
    logic    calc;
    logic    mul_start;
    logic    mul_fin;
    logic    div_start;
    logic    div_fin;
    logic    push;
    logic    out_load;
    rpn_op_t op;
  } rpn_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic b_int_zero;
    logic div_busy;
  } rpn_sts_t;

  typedef struct packed {
    logic                     printed;
    logic signed [DATA_W-1:0] value;
    logic                     underflow;
    logic                     overflow;
    logic                     div_zero;
    logic                     unknown_op;
    logic                     saturated;
  } rpn_result_t;

endpackage

>>> rtl/rpn_if.sv
// Request channel interfaces: token input and result output.
interface rpn_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] operand_value;

  modport source (output valid, output func, output operand_value, input ready);
  modport sink   (input valid, input func, input operand_value, output ready);
endinterface

interface rpn_out_if;
  logic               valid;
  logic               ready;
  logic               printed;
  logic signed [31:0] value;
  logic               underflow;
  logic               overflow;
  logic               div_zero;
  logic               unknown_op;
  logic               saturated;

  modport source (output valid, output printed, output value, output underflow,
                  output overflow, output div_zero, output unknown_op,
                  output saturated, input ready);
  modport sink   (input valid, input printed, input value, input underflow,
                  input overflow, input div_zero, input unknown_op,
                  input saturated, output ready);
endinterface

>>> rtl/rpn_stack_calculator_unit.sv
// Top level of the RPN stack calculator: controller, datapath and channel wiring.
//
// in_ch carries one token per request: func selects number push, add, sub, mul,
// div, mod, print or unknown; operand_value is the Q16.16 number for a push.
// out_ch returns exactly one result request per token with the printed value
// and the underflow, overflow, div_zero, unknown_op and saturated flags.
// Tokens are processed one at a time by the controller state machine.
// Divide and mod run in the restoring divider, which yields one quotient bit per
// cycle. The stack lives in a RAM with registered read, so each pop has an
// address state and a separate data state.
// in_ch.ready is high only while no token is in work; a finished result sits in
// the output register, so the next token is accepted while out_ch stalls. A
// token that finishes while the previous result is still held waits until
// out_ch.ready frees the register.
// Synchronous reset empties the stack and drops any held result; stack
// contents need no clearing since only entries below the pointer are read.
module rpn_stack_calculator_unit (
  input logic      clk,
  input logic      rst_n,
  rpn_in_if.sink   in_ch,
  rpn_out_if.source out_ch
);

  rpn_pkg::rpn_cmd_t    cmd;
  rpn_pkg::rpn_sts_t    sts;
  rpn_pkg::rpn_result_t result;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpn_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .operand_value(in_ch.operand_value),
    .result       (result)
  );

  assign out_ch.printed    = result.printed;
  assign out_ch.value      = result.value;
  assign out_ch.underflow  = result.underflow;
  assign out_ch.overflow   = result.overflow;
  assign out_ch.div_zero   = result.div_zero;
  assign out_ch.unknown_op = result.unknown_op;
  assign out_ch.saturated  = result.saturated;

endmodule

>>> rtl/rpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rpn_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module rpn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rpn_pkg::DATA_W-1:0] rem_init,
  input  logic [rpn_pkg::DATA_W-1:0] dvd_init,
  input  logic [rpn_pkg::DATA_W-1:0] dsr_init,
  output logic                      busy,
  output logic [rpn_pkg::DATA_W-1:0] quot,
  output logic [rpn_pkg::DATA_W-1:0] rem
);

  logic [rpn_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic [rpn_pkg::DATA_W-1:0]    rem_r;
  logic [rpn_pkg::DATA_W-1:0]    dvd_r;
  logic [rpn_pkg::DATA_W-1:0]    dsr_r;
  logic [rpn_pkg::DATA_W:0]      shifted;
  logic [rpn_pkg::DATA_W:0]      trial;
  logic                          qbit;

  always_comb begin
    shifted = {rem_r, dvd_r[rpn_pkg::DATA_W-1]};
    trial   = shifted - {1'b0, dsr_r};
    qbit    = ~trial[rpn_pkg::DATA_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - rpn_pkg::DIV_CNT_W'(1);
      if (cnt_r == rpn_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dvd_r <= dvd_init;
      dsr_r <= dsr_init;
    end else if (busy_r) begin
      rem_r <= qbit ? trial[rpn_pkg::DATA_W-1:0] : shifted[rpn_pkg::DATA_W-1:0];
      dvd_r <= {dvd_r[rpn_pkg::DATA_W-2:0], qbit};
    end
  end

  assign busy = busy_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

>>> rtl/rpn_datapath.sv
// Datapath: stack memory, stack pointer, operand registers, ALU and result register.
module rpn_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rpn_pkg::rpn_cmd_t                cmd,
  output rpn_pkg::rpn_sts_t                sts,
  input  logic signed [rpn_pkg::DATA_W-1:0] operand_value,
  output rpn_pkg::rpn_result_t             result
);

  localparam int W  = rpn_pkg::DATA_W;
  localparam int FW = rpn_pkg::FRAC_W;

  logic [rpn_pkg::SP_W-1:0]   sp_r;
  logic [rpn_pkg::SP_W-1:0]   sp_dec;
  logic                       rd_pend_r;
  logic                       rd_to_a_r;
  logic signed [W-1:0]        a_r;
  logic signed [W-1:0]        b_r;
  logic signed [W-1:0]        imm_r;
  logic signed [W-1:0]        res_r;
  logic signed [2*W-1:0]      prod_r;
  logic                       big_r;
  logic                       neg_r;
  logic                       asign_r;
  logic                       mode_mod_r;
  logic                       under_r;
  logic                       over_r;
  logic                       sat_r;
  logic                       divz_r;
  logic                       unk_r;
  logic                       print_r;
  rpn_pkg::rpn_result_t       out_r;

  logic                       pop;
  logic                       empty;
  logic                       full;
  logic                       ram_we;
  logic [W-1:0]               ram_wdata;
  logic [W-1:0]               ram_rdata;

  logic [W-1:0]               ma;
  logic [W-1:0]               mb;
  logic [W-1:0]               div_rem_init;
  logic [W-1:0]               div_dvd_init;
  logic [W-1:0]               div_dsr_init;
  logic                       div_busy;
  logic [W-1:0]               div_quot;
  logic [W-1:0]               div_rem;

  logic signed [W:0]          sum;
  logic signed [2*W-FW-1:0]   sh;
  logic [W-1:0]               mod_r32;
  logic signed [W-1:0]        res_nxt;
  logic                       sat_nxt;

  assign pop       = cmd.pop_a | cmd.pop_b;
  assign empty     = (sp_r == '0);
  assign full      = (sp_r == rpn_pkg::SP_W'(rpn_pkg::STACK_DEPTH));
  assign sp_dec    = sp_r - rpn_pkg::SP_W'(1);
  assign ram_we    = cmd.push & ~full;
  assign ram_wdata = (cmd.op == rpn_pkg::OP_NUM) ? imm_r : res_r;

  rpn_ram #(
    .WIDTH(W),
    .DEPTH(rpn_pkg::STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(sp_r[rpn_pkg::ADDR_W-1:0]),
    .wdata(ram_wdata),
    .re   (pop & ~empty),
    .raddr(sp_dec[rpn_pkg::ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r      <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= pop & ~empty;
      if (pop && !empty) begin
        sp_r <= sp_dec;
      end else if (ram_we) begin
        sp_r <= sp_r + rpn_pkg::SP_W'(1);
      end
    end
  end

  // magnitudes for the divider
  always_comb begin
    ma = a_r[W-1] ? W'(-a_r) : W'(a_r);
    mb = b_r[W-1] ? W'(-b_r) : W'(b_r);
    if (cmd.op == rpn_pkg::OP_MOD) begin
      div_rem_init = '0;
      div_dvd_init = {{(W-FW){1'b0}}, ma[W-1:FW]};
      div_dsr_init = {{(W-FW){1'b0}}, mb[W-1:FW]};
    end else begin
      div_rem_init = {{FW{1'b0}}, ma[W-1:FW]};
      div_dvd_init = {ma[FW-1:0], {FW{1'b0}}};
      div_dsr_init = mb;
    end
  end

  rpn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .rem_init(div_rem_init),
    .dvd_init(div_dvd_init),
    .dsr_init(div_dsr_init),
    .busy    (div_busy),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  always_comb begin
    sum     = (cmd.op == rpn_pkg::OP_SUB) ? ({a_r[W-1], a_r} - {b_r[W-1], b_r})
                                          : ({a_r[W-1], a_r} + {b_r[W-1], b_r});
    sh      = prod_r[2*W-1:FW];
    mod_r32 = {div_rem[W-FW-1:0], {FW{1'b0}}};
    res_nxt = '0;
    sat_nxt = 1'b0;
    if (cmd.calc) begin
      if (sum[W] != sum[W-1]) begin
        sat_nxt = 1'b1;
        res_nxt = sum[W] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
      end else begin
        res_nxt = sum[W-1:0];
      end
    end else if (cmd.mul_fin) begin
      if (!sh[2*W-FW-1] && (|sh[2*W-FW-2:W-1])) begin
        sat_nxt = 1'b1;
        res_nxt = rpn_pkg::Q_MAX;
      end else if (sh[2*W-FW-1] && !(&sh[2*W-FW-2:W-1])) begin
        sat_nxt = 1'b1;
        res_nxt = rpn_pkg::Q_MIN;
      end else begin
        res_nxt = sh[W-1:0];
      end
    end else if (cmd.div_fin) begin
      if (mode_mod_r) begin
        res_nxt = asign_r ? W'(-mod_r32) : mod_r32;
      end else if (neg_r) begin
        if (big_r || (div_quot[W-1] && (|div_quot[W-2:0]))) begin
          sat_nxt = 1'b1;
          res_nxt = rpn_pkg::Q_MIN;
        end else begin
          res_nxt = W'(-div_quot);
        end
      end else begin
        if (big_r || div_quot[W-1]) begin
          sat_nxt = 1'b1;
          res_nxt = rpn_pkg::Q_MAX;
        end else begin
          res_nxt = div_quot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      imm_r   <= operand_value;
      under_r <= 1'b0;
      over_r  <= 1'b0;
      sat_r   <= 1'b0;
      divz_r  <= 1'b0;
      unk_r   <= cmd.tok_unk;
      print_r <= 1'b0;
    end
    if (pop) begin
      rd_to_a_r <= cmd.pop_a;
    end
    if (rd_pend_r) begin
      if (rd_to_a_r) begin
        a_r <= ram_rdata;
      end else begin
        b_r <= ram_rdata;
      end
    end
    if (pop && empty) begin
      under_r <= 1'b1;
      if (cmd.pop_a) begin
        a_r <= '0;
      end else begin
        b_r <= '0;
      end
    end
    if (cmd.push && full) begin
      over_r <= 1'b1;
    end
    if (cmd.set_print) begin
      print_r <= 1'b1;
    end
    if (cmd.set_divz) begin
      divz_r <= 1'b1;
    end
    if (cmd.mul_start) begin
      prod_r <= a_r * b_r;
    end
    if (cmd.div_start) begin
      mode_mod_r <= (cmd.op == rpn_pkg::OP_MOD);
      big_r      <= ({{FW{1'b0}}, ma[W-1:FW]} >= mb);
      neg_r      <= a_r[W-1] ^ b_r[W-1];
      asign_r    <= a_r[W-1];
    end
    if (cmd.calc || cmd.mul_fin || cmd.div_fin) begin
      res_r <= res_nxt;
      if (sat_nxt) begin
        sat_r <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_r.printed    <= print_r;
      out_r.value      <= print_r ? b_r : '0;
      out_r.underflow  <= under_r;
      out_r.overflow   <= over_r;
      out_r.div_zero   <= divz_r;
      out_r.unknown_op <= unk_r;
      out_r.saturated  <= sat_r;
    end
  end

  assign sts.b_zero     = (b_r == '0);
  assign sts.b_int_zero = (mb[W-1:FW] == '0);
  assign sts.div_busy   = div_busy;
  assign result         = out_r;

endmodule

>>> rtl/rpn_ctrl.sv
// Controller: token sequencing state machine and output valid flag.
module rpn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rpn_pkg::rpn_sts_t sts,
  output rpn_pkg::rpn_cmd_t cmd
);

  rpn_pkg::rpn_state_t state_r;
  rpn_pkg::rpn_state_t state_nxt;
  rpn_pkg::rpn_op_t    op_r;
  rpn_pkg::rpn_op_t    tok;
  logic                out_valid_r;
  logic                out_free;
  logic                b_is_zero;

  assign tok       = rpn_pkg::rpn_op_t'(in_func);
  assign out_free  = ~out_valid_r | out_ready;
  assign b_is_zero = (op_r == rpn_pkg::OP_MOD) ? sts.b_int_zero : sts.b_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpn_pkg::S_IDLE;
      op_r        <= rpn_pkg::OP_NUM;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.accept) begin
        op_r <= tok;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpn_pkg::S_IDLE: begin
        if (in_valid) begin
          case (tok) inside
            rpn_pkg::OP_NUM: state_nxt = rpn_pkg::S_PUSH;
            rpn_pkg::OP_UNK: state_nxt = rpn_pkg::S_DONE;
            default:         state_nxt = rpn_pkg::S_POP_B;
          endcase
        end
      end
      rpn_pkg::S_POP_B: state_nxt = rpn_pkg::S_WAIT_B;
      rpn_pkg::S_WAIT_B: begin
        case (op_r) inside
          rpn_pkg::OP_PRINT:                 state_nxt = rpn_pkg::S_DONE;
          rpn_pkg::OP_DIV, rpn_pkg::OP_MOD:  state_nxt = rpn_pkg::S_CHK_B;
          default:                           state_nxt = rpn_pkg::S_POP_A;
        endcase
      end
      rpn_pkg::S_CHK_B:  state_nxt = b_is_zero ? rpn_pkg::S_DONE : rpn_pkg::S_POP_A;
      rpn_pkg::S_POP_A:  state_nxt = rpn_pkg::S_WAIT_A;
      rpn_pkg::S_WAIT_A: state_nxt = rpn_pkg::S_EXEC;
      rpn_pkg::S_EXEC: begin
        case (op_r) inside
          rpn_pkg::OP_MUL:                   state_nxt = rpn_pkg::S_MUL;
          rpn_pkg::OP_DIV, rpn_pkg::OP_MOD:  state_nxt = rpn_pkg::S_DIV;
          default:                           state_nxt = rpn_pkg::S_PUSH;
        endcase
      end
      rpn_pkg::S_MUL:     state_nxt = rpn_pkg::S_PUSH;
      rpn_pkg::S_DIV:     state_nxt = sts.div_busy ? rpn_pkg::S_DIV : rpn_pkg::S_DIV_FIN;
      rpn_pkg::S_DIV_FIN: state_nxt = rpn_pkg::S_PUSH;
      rpn_pkg::S_PUSH:    state_nxt = rpn_pkg::S_DONE;
      rpn_pkg::S_DONE:    state_nxt = out_free ? rpn_pkg::S_IDLE : rpn_pkg::S_DONE;
      default:            state_nxt = rpn_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.op   = op_r;
    in_ready = 1'b0;
    unique case (state_r)
      rpn_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.accept  = in_valid;
        cmd.tok_unk = (tok == rpn_pkg::OP_UNK);
      end
      rpn_pkg::S_POP_B:  cmd.pop_b     = 1'b1;
      rpn_pkg::S_WAIT_B: cmd.set_print = (op_r == rpn_pkg::OP_PRINT);
      rpn_pkg::S_CHK_B:  cmd.set_divz  = b_is_zero;
      rpn_pkg::S_POP_A:  cmd.pop_a     = 1'b1;
      rpn_pkg::S_WAIT_A: ;
      rpn_pkg::S_EXEC: begin
        case (op_r) inside
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: cmd.calc      = 1'b1;
          rpn_pkg::OP_MUL:                  cmd.mul_start = 1'b1;
          rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: cmd.div_start = 1'b1;
          default: ;
        endcase
      end
      rpn_pkg::S_MUL:     cmd.mul_fin  = 1'b1;
      rpn_pkg::S_DIV:     ;
      rpn_pkg::S_DIV_FIN: cmd.div_fin  = 1'b1;
      rpn_pkg::S_PUSH:    cmd.push     = 1'b1;
      rpn_pkg::S_DONE:    cmd.out_load = out_free;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/rpn_checker.sv
// Port-level assertions for the RPN stack calculator, bound to the top level.
module rpn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        printed,
  input logic [31:0] value,
  input logic        underflow,
  input logic        overflow,
  input logic        div_zero,
  input logic        unknown_op,
  input logic        saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(printed))
    else $error("result request changed while stalled");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !printed |-> value == 32'd0)
    else $error("value nonzero on a non-print result");

  a_unk_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && unknown_op |-> !printed && !underflow && !overflow && !div_zero && !saturated)
    else $error("unknown operator result carries other flags");

  a_divz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && div_zero |-> !overflow && !saturated && !printed)
    else $error("divide by zero result carries push or print flags");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rpn_stack_calculator_unit rpn_checker u_rpn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .printed   (out_ch.printed),
  .value     (out_ch.value),
  .underflow (out_ch.underflow),
  .overflow  (out_ch.overflow),
  .div_zero  (out_ch.div_zero),
  .unknown_op(out_ch.unknown_op),
  .saturated (out_ch.saturated)
);

>>> bench/rpn_result_checker.sv
`timescale 1ns / 1ps
// Channel monitor and scoreboard for the RPN stack calculator: predicts each result and compares.
module rpn_result_checker
  import rpn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rpn_in_if    in_ch,
  rpn_out_if   out_ch,
  output int   mismatches,
  output int   outstanding
);

  logic signed [DATA_W-1:0] calc_stack [STACK_DEPTH];
  int                       calc_sp;
  rpn_result_t              pending_results [$];

  function automatic longint pop_entry(inout bit uf);
    if (calc_sp > 0) begin
      calc_sp--;
      return longint'(calc_stack[calc_sp]);
    end
    uf = 1'b1;
    return 0;
  endfunction

  function automatic void push_entry(input longint v, inout bit ovf);
    if (calc_sp < STACK_DEPTH) begin
      calc_stack[calc_sp] = v[DATA_W-1:0];
      calc_sp++;
    end else begin
      ovf = 1'b1;
    end
  endfunction

  function automatic longint sat_q(input longint v, inout bit sat);
    if (v > longint'(Q_MAX)) begin
      sat = 1'b1;
      return longint'(Q_MAX);
    end
    if (v < longint'(Q_MIN)) begin
      sat = 1'b1;
      return longint'(Q_MIN);
    end
    return v;
  endfunction

  function automatic rpn_result_t calc_token_result(input rpn_op_t op,
                                                    input logic signed [DATA_W-1:0] opnd);
    rpn_result_t r;
    bit          uf;
    bit          ovf;
    bit          sat;
    longint      a;
    longint      b;
    longint      one_q;
    r     = '0;
    uf    = 1'b0;
    ovf   = 1'b0;
    sat   = 1'b0;
    one_q = longint'(1) <<< FRAC_W;
    case (op)
      OP_NUM: push_entry(longint'(opnd), ovf);
      OP_ADD: begin
        b = pop_entry(uf);
        a = pop_entry(uf);
        push_entry(sat_q(a + b, sat), ovf);
      end
      OP_SUB: begin
        b = pop_entry(uf);
        a = pop_entry(uf);
        push_entry(sat_q(a - b, sat), ovf);
      end
      OP_MUL: begin
        b = pop_entry(uf);
        a = pop_entry(uf);
        // arithmetic shift floors, i.e. rounds toward minus infinity
        push_entry(sat_q((a * b) >>> FRAC_W, sat), ovf);
      end
      OP_DIV: begin
        b = pop_entry(uf);
        if (b != 0) begin
          a = pop_entry(uf);
          push_entry(sat_q((a * one_q) / b, sat), ovf);
        end else begin
          r.div_zero = 1'b1;
        end
      end
      OP_MOD: begin
        b = pop_entry(uf) / one_q;
        if (b != 0) begin
          a = pop_entry(uf) / one_q;
          push_entry((a % b) * one_q, ovf);
        end else begin
          r.div_zero = 1'b1;
        end
      end
      OP_PRINT: begin
        a         = pop_entry(uf);
        r.value   = a[DATA_W-1:0];
        r.printed = 1'b1;
      end
      default: r.unknown_op = 1'b1;
    endcase
    r.underflow = uf;
    r.overflow  = ovf;
    r.saturated = sat;
    return r;
  endfunction

  function automatic void check_field(input string fname,
                                      input logic signed [DATA_W-1:0] want,
                                      input logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
               $time, fname, want, want, got, got);
    end
  endfunction

  always @(posedge clk) begin
    rpn_result_t want;
    if (!rst_n) begin
      calc_sp = 0;
      pending_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request pending, actual value %0d", $time,
                   out_ch.value);
        end else begin
          want = pending_results.pop_front();
          check_field("printed",    want.printed,    out_ch.printed);
          check_field("value",      want.value,      out_ch.value);
          check_field("underflow",  want.underflow,  out_ch.underflow);
          check_field("overflow",   want.overflow,   out_ch.overflow);
          check_field("div_zero",   want.div_zero,   out_ch.div_zero);
          check_field("unknown_op", want.unknown_op, out_ch.unknown_op);
          check_field("saturated",  want.saturated,  out_ch.saturated);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(calc_token_result(rpn_op_t'(in_ch.func),
                                                    in_ch.operand_value));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

>>> bench/tb_rpn_stack_calculator_unit.sv
`timescale 1ns / 1ps
// Testbench top for the RPN stack calculator: clock, reset, token stimulus and verdict.
module tb_rpn_stack_calculator_unit;
  import rpn_pkg::*;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   hold_left;
  int   depth_est;

  rpn_in_if  in_ch ();
  rpn_out_if out_ch ();

  rpn_stack_calculator_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rpn_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_token(input rpn_op_t op, input logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= op;
    in_ch.operand_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_operand();
    case ($urandom_range(9))
      0, 1, 2: return 32'(($urandom_range(40) - 20) << FRAC_W);
      3, 4:    return 32'($urandom_range(1 << 18) - (1 << 17));
      5:       return Q_MAX;
      6:       return Q_MIN;
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic send_random_token();
    int      r;
    rpn_op_t op;
    r = $urandom_range(99);
    if (r < 8)                         op = rpn_op_t'($urandom_range(7));
    else if (depth_est < 2 || r < 42)  op = OP_NUM;
    else if (r < 52)                   op = OP_ADD;
    else if (r < 61)                   op = OP_SUB;
    else if (r < 70)                   op = OP_MUL;
    else if (r < 79)                   op = OP_DIV;
    else if (r < 86)                   op = OP_MOD;
    else if (r < 96)                   op = OP_PRINT;
    else                               op = OP_UNK;
    send_token(op, (op == OP_NUM) ? rand_operand() : 32'($urandom));
    case (op)
      OP_NUM:   if (depth_est < STACK_DEPTH) depth_est++;
      OP_PRINT: if (depth_est > 0) depth_est--;
      OP_UNK:   ;
      default:  depth_est = (depth_est > 1) ? depth_est - 1 : 1;
    endcase
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = OP_NUM;
    in_ch.operand_value = '0;
    tx_idle_pct         = 0;
    rx_idle_pct         = 0;
    hold_left           = 0;
    depth_est           = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty-stack pops, saturation both ways, zero divisors, unknown op
    send_token(OP_PRINT, 32'($urandom));
    send_token(OP_ADD,   32'($urandom));
    send_token(OP_NUM,   Q_MAX);
    send_token(OP_NUM,   32'sh0000_0001);
    send_token(OP_ADD,   32'($urandom));
    send_token(OP_NUM,   Q_MIN);
    send_token(OP_SUB,   32'($urandom));
    send_token(OP_NUM,   Q_MAX);
    send_token(OP_MUL,   32'($urandom));
    send_token(OP_NUM,   32'shFFFF_FFFF);
    send_token(OP_MUL,   32'($urandom));
    send_token(OP_NUM,   32'sh0000_0000);
    send_token(OP_DIV,   32'($urandom));
    send_token(OP_NUM,   Q_MIN);
    send_token(OP_NUM,   32'sh0000_8000);
    send_token(OP_DIV,   32'($urandom));
    send_token(OP_NUM,   32'sh0000_8000);
    send_token(OP_MOD,   32'($urandom));
    send_token(OP_NUM,   32'shFFFD_0000);
    send_token(OP_MOD,   32'($urandom));
    send_token(OP_UNK,   32'($urandom));
    repeat (4) send_token(OP_PRINT, 32'($urandom));
    send_token(OP_MOD,   32'($urandom));
    wait_drained();

    tx_idle_pct = 17;
    rx_idle_pct = 54;
    depth_est   = 0;
    repeat (230) send_random_token();
    wait_drained();

    // fill past the top of the stack, then work on a full stack
    tx_idle_pct = 54;
    rx_idle_pct = 17;
    repeat (STACK_DEPTH + 7) begin
      send_token(OP_NUM, rand_operand());
      if (depth_est < STACK_DEPTH) depth_est++;
    end
    repeat (100) send_random_token();
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left   = 300;
    repeat (230) send_random_token();
    wait_drained();

    repeat (60) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
